// File: rtl/core/uptx_pkg.sv
// Shared types and constants of the USB PD transmit protocol layer.
package uptx_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] QUEUE_FULL = CNT_W'(QUEUE_DEPTH);

   localparam logic [4:0] TYPE_GOODCRC    = 5'd1;
   localparam logic [4:0] TYPE_SOFT_RESET = 5'd13;

   typedef enum logic [2:0] {
      OP_RESET      = 3'd0,
      OP_DISCARD    = 3'd1,
      OP_PUSH       = 3'd2,
      OP_TX_SENT    = 3'd3,
      OP_RETRY_FAIL = 3'd4
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] message_header;
      logic [15:0] goodcrc_header;
   } event_type;

   typedef struct packed {
      logic        send_valid;
      logic [15:0] send_header;
      logic        phy_reset;
      logic        tx_done;
      logic        tx_error;
      logic        push_dropped;
   } result_type;

endpackage

// File: rtl/core/uptx_engine.sv
// Protocol state, header queue and per-event result logic.
module uptx_engine import uptx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  event_type  evt,
   output result_type res
);

   logic             awaiting_ff, awaiting_in;
   logic [2:0]       msg_id_ff, msg_id_in;
   logic             request_ff, request_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      queue_ff [QUEUE_DEPTH];
   logic [15:0]      queue_in [QUEUE_DEPTH];

   always_comb begin
      logic        push_ok;
      logic        pop;
      logic [15:0] head;
      logic [15:0] queue_mid [QUEUE_DEPTH];

      res         = '0;
      awaiting_in = awaiting_ff;
      msg_id_in   = msg_id_ff;
      request_in  = request_ff;
      count_in    = count_ff;
      push_ok     = 1'b0;
      pop         = 1'b0;
      head        = '0;

      case (evt.opcode)
         OP_RESET: begin
            res.phy_reset = 1'b1;
            res.tx_error  = (count_ff != '0);
            count_in      = '0;
            request_in    = 1'b0;
            awaiting_in   = 1'b0;
         end
         OP_DISCARD: begin
            if (awaiting_ff) begin
               msg_id_in     = msg_id_ff + 3'd1;
               res.phy_reset = 1'b1;
               res.tx_error  = (count_ff != '0);
               count_in      = '0;
               request_in    = 1'b0;
               awaiting_in   = 1'b0;
            end
         end
         OP_PUSH: begin
            if (count_ff < QUEUE_FULL) begin
               push_ok    = 1'b1;
               count_in   = count_ff + CNT_W'(1);
               request_in = 1'b1;
            end else begin
               res.push_dropped = 1'b1;
            end
         end
         OP_TX_SENT: begin
            if (awaiting_ff) begin
               if (evt.goodcrc_header[4:0] == TYPE_GOODCRC &&
                   evt.goodcrc_header[14:12] == 3'd0 &&
                   evt.goodcrc_header[11:9] == msg_id_ff) begin
                  res.tx_done = 1'b1;
               end else begin
                  res.tx_error = 1'b1;
               end
               msg_id_in   = msg_id_ff + 3'd1;
               awaiting_in = 1'b0;
            end
         end
         OP_RETRY_FAIL: begin
            if (awaiting_ff) begin
               res.tx_error = 1'b1;
               msg_id_in    = msg_id_ff + 3'd1;
               awaiting_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // append at the fill level, then pop from the head in the same cycle
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_mid[i] = (push_ok && count_ff == CNT_W'(i)) ? evt.message_header
                                                           : queue_ff[i];
      end

      if (!awaiting_in && request_in) begin
         request_in = 1'b0;
         if (count_in != '0) begin
            pop      = 1'b1;
            head     = queue_mid[0];
            count_in = count_in - CNT_W'(1);
            if (head[4:0] == TYPE_SOFT_RESET && head[14:12] == 3'd0) begin
               msg_id_in = 3'd0;
            end
            res.send_valid  = 1'b1;
            res.send_header = {head[15:12], msg_id_in, head[8:0]};
            awaiting_in     = 1'b1;
         end
      end

      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         if (pop) begin
            queue_in[i] = queue_mid[i + 1];
         end else begin
            queue_in[i] = queue_mid[i];
         end
      end
      queue_in[QUEUE_DEPTH - 1] = queue_mid[QUEUE_DEPTH - 1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         msg_id_ff   <= '0;
         request_ff  <= 1'b0;
         count_ff    <= '0;
      end else if (fire) begin
         awaiting_ff <= awaiting_in;
         msg_id_ff   <= msg_id_in;
         request_ff  <= request_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         queue_ff <= queue_in;
      end
   end

   a_send_sets_awaiting: assert property (@(posedge clock) disable iff (reset)
      fire && res.send_valid |=> awaiting_ff)
      else $error("send issued but block is not awaiting the PHY");

   a_done_error_exclusive: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(res.tx_done && res.tx_error))
      else $error("done and error reported together");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_FULL)
      else $error("queue count exceeds depth");

   a_reset_flushes: assert property (@(posedge clock) disable iff (reset)
      fire && res.phy_reset |=> count_ff == '0 && !awaiting_ff && !request_ff)
      else $error("PHY reset did not flush the queue");

endmodule

// File: rtl/core/usb_pd_tx_protocol_layer.sv
// Top level of the USB PD transmit protocol layer with stream handshakes.
//
//  channel   dir  tdata                                   tuser
//  req_      in   [15:0] message_header [31:16] goodcrc   [2:0] opcode
//  rsp_      out  [15:0] send_header [16] phy_reset ...   [0] send_valid
//
// One transaction per cycle sustained while rsp_tready stays high; each
// event goes from the input register through the engine's state update
// into the result register, which loads when the input register advances.
// Reset is synchronous and clears handshake and protocol state; queue
// entries carry no reset. A stalled result holds and blocks the input
// register only once both are full.
module usb_pd_tx_protocol_layer import uptx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // message_header[15:0], goodcrc_header[31:16]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // send_header[15:0], phy_reset, tx_done,
                                    // tx_error, push_dropped, zero fill
   output logic [0:0]  rsp_tuser    // send_valid[0]
);

   logic       in_valid_ff;
   event_type  in_evt_ff;
   logic       out_valid_ff;
   result_type out_res_ff;
   result_type res;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_evt_ff.opcode         <= opcode_type'(req_tuser);
         in_evt_ff.message_header <= req_tdata[15:0];
         in_evt_ff.goodcrc_header <= req_tdata[31:16];
      end
   end

   uptx_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .evt   (in_evt_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.send_valid;
   assign rsp_tdata  = {4'd0, out_res_ff.push_dropped, out_res_ff.tx_error,
                        out_res_ff.tx_done, out_res_ff.phy_reset,
                        out_res_ff.send_header};

endmodule

// File: dv/tb_usb_pd_tx_protocol_layer.sv
// Self-checking testbench for the USB PD transmit protocol layer stream top level.
`timescale 1ns / 1ps

module tb_usb_pd_tx_protocol_layer;
   import uptx_pkg::*;

   localparam int RANDOM_EVENTS   = 900;
   localparam int TAIL_EVENTS     = 150;
   localparam int HOLD_OFF_AT     = 300;
   localparam int DRAIN_AT        = 600;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 5000;
   localparam int SETTLE_CYCLES   = 10;

   // opcodes the block must ignore
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   // Tracks protocol state and holds the outcomes still owed by the block.
   class pd_tx_tracker;
      bit          awaiting_phy;
      bit [2:0]    message_id;
      bit          request_latched;
      logic [15:0] header_fifo[$];
      result_type  pending_outcomes[$];
      int          failures;

      function void flush_phy(inout result_type r);
         r.phy_reset = 1'b1;
         if (header_fifo.size() > 0) r.tx_error = 1'b1;
         header_fifo.delete();
         request_latched = 1'b0;
         awaiting_phy    = 1'b0;
      endfunction

      function void note_event(logic [2:0] op, logic [15:0] mh, logic [15:0] gh);
         result_type  r;
         logic [15:0] h;
         r = '0;
         case (op)
            OP_RESET: flush_phy(r);
            OP_DISCARD: begin
               if (awaiting_phy) begin
                  message_id++;
                  flush_phy(r);
               end
            end
            OP_PUSH: begin
               if (header_fifo.size() < QUEUE_DEPTH) begin
                  header_fifo.push_back(mh);
                  request_latched = 1'b1;
               end else begin
                  r.push_dropped = 1'b1;
               end
            end
            OP_TX_SENT: begin
               if (awaiting_phy) begin
                  if (gh[4:0] == TYPE_GOODCRC && gh[14:12] == 3'd0 && gh[11:9] == message_id)
                     r.tx_done = 1'b1;
                  else
                     r.tx_error = 1'b1;
                  message_id++;
                  awaiting_phy = 1'b0;
               end
            end
            OP_RETRY_FAIL: begin
               if (awaiting_phy) begin
                  r.tx_error = 1'b1;
                  message_id++;
                  awaiting_phy = 1'b0;
               end
            end
            default: ;
         endcase
         // launch the next queued header in the same transaction
         if (!awaiting_phy && request_latched) begin
            request_latched = 1'b0;
            if (header_fifo.size() > 0) begin
               h = header_fifo.pop_front();
               if (h[4:0] == TYPE_SOFT_RESET && h[14:12] == 3'd0) message_id = 3'd0;
               h[11:9]       = message_id;
               r.send_valid  = 1'b1;
               r.send_header = h;
               awaiting_phy  = 1'b1;
            end
         end
         pending_outcomes.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
         end
      endfunction

      function void check_outcome(result_type got);
         result_type exp;
         if (pending_outcomes.size() == 0) begin
            failures++;
            $display("%0t: result with none outstanding, expected none, actual %h", $time, got);
            return;
         end
         exp = pending_outcomes.pop_front();
         compare_field("send_valid", exp.send_valid, got.send_valid);
         compare_field("send_header", exp.send_header, got.send_header);
         compare_field("phy_reset", exp.phy_reset, got.phy_reset);
         compare_field("tx_done", exp.tx_done, got.tx_done);
         compare_field("tx_error", exp.tx_error, got.tx_error);
         compare_field("push_dropped", exp.push_dropped, got.push_dropped);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   pd_tx_tracker tracker = new;
   bit quiet_tail;
   bit hold_off_request;
   int hold_left;
   int idle_cycles;

   usb_pd_tx_protocol_layer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] make_goodcrc(logic [2:0] id, logic [15:0] noise);
      logic [15:0] h;
      h        = noise;
      h[4:0]   = TYPE_GOODCRC;
      h[14:12] = 3'd0;
      h[11:9]  = id;
      return h;
   endfunction

   // Offer one event, optionally after an idle burst, and hold until accepted.
   task automatic send_event(input logic [2:0] op, input logic [15:0] mh,
                             input logic [15:0] gh);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {gh, mh};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      tracker.note_event(op, mh, gh);
   endtask

   // Stop offering and wait until every outcome has been returned.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending_outcomes.size() != 0);
   endtask

   // Mostly well-formed exchanges, with corrupted acknowledgments and noise mixed in.
   task automatic random_event();
      logic [2:0]  op;
      logic [15:0] mh;
      logic [15:0] gh;
      int          pick;
      pick = $urandom_range(0, 99);
      mh   = 16'($urandom);
      gh   = 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         mh[4:0]   = TYPE_SOFT_RESET;
         mh[14:12] = 3'd0;
      end
      if (tracker.awaiting_phy) begin
         if (pick < 45) begin
            op = OP_TX_SENT;
            gh = make_goodcrc(tracker.message_id, gh);
         end else if (pick < 55) begin
            op = OP_TX_SENT;
            gh = make_goodcrc(tracker.message_id, gh);
            case ($urandom_range(0, 3))
               0: gh[4:0]   = gh[4:0] ^ 5'($urandom_range(1, 31));
               1: gh[14:12] = gh[14:12] ^ 3'($urandom_range(1, 7));
               2: gh[11:9]  = gh[11:9] ^ 3'($urandom_range(1, 7));
               default: gh  = 16'($urandom);
            endcase
         end else if (pick < 63) begin
            op = OP_RETRY_FAIL;
         end else if (pick < 68) begin
            op = OP_DISCARD;
         end else if (pick < 90) begin
            op = OP_PUSH;
         end else if (pick < 94) begin
            op = OP_RESET;
         end else begin
            op = 3'($urandom_range(0, 7));
         end
      end else begin
         if (pick < 70) op = OP_PUSH;
         else if (pick < 76) op = OP_RESET;
         else op = 3'($urandom_range(0, 7));
      end
      send_event(op, mh, gh);
   endtask

   // Result monitor and receiver backpressure.
   always @(posedge clock) begin
      result_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.send_valid   = rsp_tuser[0];
         seen.send_header  = rsp_tdata[15:0];
         seen.phy_reset    = rsp_tdata[16];
         seen.tx_done      = rsp_tdata[17];
         seen.tx_error     = rsp_tdata[18];
         seen.push_dropped = rsp_tdata[19];
         tracker.check_outcome(seen);
      end
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left        = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         hold_left  = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Abort when no transaction moves on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("usb_pd_tx_protocol_layer regression: fail");
         $finish;
      end
   end

   initial begin
      int  issued;
      bit  held;
      bit  drained;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // events ignored while idle, and unused opcodes
      send_event(OP_TX_SENT, 16'h0000, make_goodcrc(3'd0, 16'h0000));
      send_event(OP_RETRY_FAIL, 16'hFFFF, 16'hFFFF);
      send_event(OP_DISCARD, 16'hFFFF, 16'hFFFF);
      send_event(OP_SPARE_FIRST, 16'hFFFF, 16'hFFFF);
      send_event(OP_SPARE_LAST, 16'h0000, 16'h0000);
      // all-ones header, then a clean acknowledgment
      send_event(OP_PUSH, 16'hFFFF, 16'h0000);
      send_event(OP_TX_SENT, 16'h0000, make_goodcrc(tracker.message_id, 16'hFFFF));
      // all-zeros header, then a garbage acknowledgment
      send_event(OP_PUSH, 16'h0000, 16'hFFFF);
      send_event(OP_TX_SENT, 16'h0000, 16'hFFFF);
      // soft reset clears the ID counter before stamping
      send_event(OP_PUSH, {1'b1, 3'd0, 3'd7, 4'hF, TYPE_SOFT_RESET}, 16'h0000);
      send_event(OP_RETRY_FAIL, 16'h0000, 16'h0000);
      // soft reset type with data objects leaves the counter alone
      send_event(OP_PUSH, {1'b0, 3'd1, 3'd0, 4'h0, TYPE_SOFT_RESET}, 16'h0000);
      send_event(OP_TX_SENT, 16'h0000,
                 make_goodcrc(3'(tracker.message_id + 3'd1), 16'h0000));
      // overfill the queue, then discard while sending with headers queued
      repeat (6) send_event(OP_PUSH, 16'($urandom), 16'h0000);
      send_event(OP_DISCARD, 16'h0000, 16'h0000);
      send_event(OP_RESET, 16'h0000, 16'h0000);
      // acknowledgment and next launch land in one transaction
      send_event(OP_PUSH, 16'h1234, 16'h0000);
      send_event(OP_PUSH, 16'hABCD, 16'h0000);
      send_event(OP_TX_SENT, 16'h0000, make_goodcrc(tracker.message_id, 16'h0000));
      send_event(OP_RESET, 16'h0000, 16'h0000);

      issued  = 0;
      held    = 1'b0;
      drained = 1'b0;
      while (issued < RANDOM_EVENTS) begin
         quiet_tail = (issued >= RANDOM_EVENTS - TAIL_EVENTS);
         if (!held && issued >= HOLD_OFF_AT) begin
            held             = 1'b1;
            hold_off_request = 1'b1;
         end
         if (!drained && issued >= DRAIN_AT) begin
            drained = 1'b1;
            drain_results();
         end
         if ($urandom_range(0, 29) == 0) begin
            repeat (6) begin
               send_event(OP_PUSH, 16'($urandom), 16'($urandom));
               issued++;
            end
         end else begin
            random_event();
            issued++;
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_outcomes.size() == 0) begin
         $display("usb_pd_tx_protocol_layer regression: pass");
      end else begin
         $display("usb_pd_tx_protocol_layer regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/uptx_pkg.sv
rtl/core/uptx_engine.sv
rtl/core/usb_pd_tx_protocol_layer.sv
dv/tb_usb_pd_tx_protocol_layer.sv
